// ----- src/udp_port_bind_demux_table_defines.svh -----
// Assertion macros used by the top-level binding table module.
`ifndef UDP_PORT_BIND_DEMUX_TABLE_DEFINES_SVH
`define UDP_PORT_BIND_DEMUX_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define UDPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define UDPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/udpd_pkg.sv -----
package udpd_pkg;

   localparam int SLOTS_DEFAULT = 32;

   localparam logic [15:0] EPHEM_LOW_RESET  = 16'd49152;
   localparam logic [15:0] EPHEM_HIGH_RESET = 16'd65535;
   localparam logic [15:0] CURSOR_RESET     = 16'd49152;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPHEM_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPHEM_HIGH = 1'd1;

   typedef enum logic [1:0] {
      MODE_BIND   = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_UNBIND = 2'd2,
      MODE_PICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INUSE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] port;
      logic [31:0] addr;
      logic [4:0]  slot;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  result_slot;
      logic [15:0] result_port;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_EPH_INIT,
      S_EPH_STEP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic eph_init;
      logic eph_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_eph;
      logic eph_found;
      logic eph_last;
   } sts_type;

endpackage

// ----- src/udpd_ctrl.sv -----
module udpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  udpd_pkg::sts_type sts,
   output udpd_pkg::cmd_type cmd
);

   udpd_pkg::state_type state_ff;
   udpd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udpd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         udpd_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = udpd_pkg::S_COMPARE;
            end
         end
         udpd_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = sts.need_eph ? udpd_pkg::S_EPH_INIT : udpd_pkg::S_FINISH;
         end
         udpd_pkg::S_EPH_INIT: begin
            cmd.eph_init = 1'b1;
            state_in     = udpd_pkg::S_EPH_STEP;
         end
         udpd_pkg::S_EPH_STEP: begin
            // probe one port per cycle until a free one turns up or the range is spent
            cmd.eph_step = 1'b1;
            if (sts.eph_found || sts.eph_last) begin
               state_in = udpd_pkg::S_FINISH;
            end
         end
         udpd_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = udpd_pkg::S_IDLE;
         end
         default: begin
            state_in = udpd_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/udpd_dp.sv -----
module udpd_dp #(
   parameter int SLOTS = udpd_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  udpd_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [udpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                        csr_wdata,
   input  udpd_pkg::cmd_type                  cmd,
   output udpd_pkg::sts_type                  sts,
   output logic                               rsp_valid,
   output udpd_pkg::rsp_type                  rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);

   // lowest set bit: {found, index}
   function automatic logic [IDX_W:0] lowest(input logic [SLOTS-1:0] v);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, IDX_W'(i)};
         end
      end
      return r;
   endfunction

   udpd_pkg::req_type req_ff, req_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [15:0]       port_ff [SLOTS];
   logic [15:0]       port_in [SLOTS];
   logic [31:0]       addr_ff [SLOTS];
   logic [31:0]       addr_in [SLOTS];
   logic [SLOTS-1:0]  exact_ff, exact_in;
   logic [SLOTS-1:0]  wild_ff, wild_in;
   logic [15:0]       low_ff, low_in;
   logic [15:0]       high_ff, high_in;
   logic [15:0]       cursor_ff, cursor_in;
   logic [15:0]       lo_ff, lo_in;
   logic [15:0]       hi_ff, hi_in;
   logic [15:0]       count_ff, count_in;
   logic [15:0]       chosen_ff, chosen_in;
   logic              eph_ok_ff, eph_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   udpd_pkg::rsp_type rsp_ff, rsp_in;

   logic [15:0]      eff_lo;
   logic [15:0]      eff_hi;
   logic [SLOTS-1:0] port_eq;
   logic [SLOTS-1:0] used_vec;
   logic             need_eph;
   logic [15:0]      bind_port;
   logic [IDX_W:0]   ex_hit;
   logic [IDX_W:0]   wd_hit;
   logic [IDX_W:0]   fr_hit;
   logic [8:0]       slot_w;
   logic [IDX_W-1:0] uidx;
   logic             u_in_range;

   assign eff_lo = (low_ff == 16'd0) ? 16'd1 : low_ff;
   assign eff_hi = (high_ff < eff_lo) ? eff_lo : high_ff;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         port_eq[i]  = valid_ff[i] && (port_ff[i] == req_ff.port);
         used_vec[i] = valid_ff[i] && (port_ff[i] == cursor_ff);
      end
   end

   assign need_eph = (req_ff.mode == udpd_pkg::MODE_PICK) ||
                     ((req_ff.mode == udpd_pkg::MODE_BIND) && (req_ff.port == 16'd0));

   assign sts.need_eph  = need_eph;
   assign sts.eph_found = ~(|used_vec);
   assign sts.eph_last  = (count_ff == (hi_ff - lo_ff));

   assign bind_port  = need_eph ? chosen_ff : req_ff.port;
   assign ex_hit     = lowest(exact_ff);
   assign wd_hit     = lowest(wild_ff);
   assign fr_hit     = lowest(~valid_ff);
   assign slot_w     = 9'(req_ff.slot);
   assign uidx       = slot_w[IDX_W-1:0];
   assign u_in_range = slot_w < 9'(SLOTS);

   always_comb begin
      req_in       = cmd.load ? req_data : req_ff;
      valid_in     = valid_ff;
      port_in      = port_ff;
      addr_in      = addr_ff;
      exact_in     = exact_ff;
      wild_in      = wild_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      cursor_in    = cursor_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      chosen_in    = chosen_ff;
      eph_ok_in    = eph_ok_ff;
      rsp_valid_in = cmd.finish;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         if (csr_index == udpd_pkg::CSR_EPHEM_LOW) begin
            low_in = csr_wdata;
         end
         if (csr_index == udpd_pkg::CSR_EPHEM_HIGH) begin
            high_in = csr_wdata;
         end
      end

      if (cmd.compare) begin
         for (int i = 0; i < SLOTS; i++) begin
            exact_in[i] = port_eq[i] && (addr_ff[i] == req_ff.addr);
            wild_in[i]  = port_eq[i] && (addr_ff[i] == 32'd0);
         end
      end

      if (cmd.eph_init) begin
         lo_in     = eff_lo;
         hi_in     = eff_hi;
         count_in  = '0;
         eph_ok_in = 1'b0;
         if ((cursor_ff < eff_lo) || (cursor_ff > eff_hi)) begin
            cursor_in = eff_lo;
         end
      end

      if (cmd.eph_step) begin
         cursor_in = (cursor_ff >= hi_ff) ? lo_ff : cursor_ff + 16'd1;
         count_in  = count_ff + 16'd1;
         if (sts.eph_found) begin
            eph_ok_in = 1'b1;
            chosen_in = cursor_ff;
         end
      end

      if (cmd.finish) begin
         rsp_in.status      = udpd_pkg::ST_NOMATCH;
         rsp_in.result_slot = '0;
         rsp_in.result_port = '0;
         case (req_ff.mode)
            udpd_pkg::MODE_BIND: begin
               if (need_eph ? !eph_ok_ff : (|exact_ff)) begin
                  rsp_in.status = udpd_pkg::ST_INUSE;
               end else if (fr_hit[IDX_W]) begin
                  valid_in[fr_hit[IDX_W-1:0]] = 1'b1;
                  port_in[fr_hit[IDX_W-1:0]]  = bind_port;
                  addr_in[fr_hit[IDX_W-1:0]]  = req_ff.addr;
                  rsp_in.status      = udpd_pkg::ST_OK;
                  rsp_in.result_slot = 5'(fr_hit[IDX_W-1:0]);
                  rsp_in.result_port = bind_port;
               end else begin
                  rsp_in.status = udpd_pkg::ST_FULL;
               end
            end
            udpd_pkg::MODE_LOOKUP: begin
               // exact address wins over the wildcard binding
               if (ex_hit[IDX_W]) begin
                  rsp_in.status      = udpd_pkg::ST_OK;
                  rsp_in.result_slot = 5'(ex_hit[IDX_W-1:0]);
                  rsp_in.result_port = req_ff.port;
               end else if (wd_hit[IDX_W]) begin
                  rsp_in.status      = udpd_pkg::ST_OK;
                  rsp_in.result_slot = 5'(wd_hit[IDX_W-1:0]);
                  rsp_in.result_port = req_ff.port;
               end
            end
            udpd_pkg::MODE_UNBIND: begin
               if (u_in_range && valid_ff[uidx]) begin
                  valid_in[uidx]     = 1'b0;
                  rsp_in.status      = udpd_pkg::ST_OK;
                  rsp_in.result_slot = req_ff.slot;
                  rsp_in.result_port = port_ff[uidx];
               end
            end
            udpd_pkg::MODE_PICK: begin
               if (eph_ok_ff) begin
                  rsp_in.status      = udpd_pkg::ST_OK;
                  rsp_in.result_port = chosen_ff;
               end else begin
                  rsp_in.status = udpd_pkg::ST_INUSE;
               end
            end
            default: begin
               rsp_in.status = udpd_pkg::ST_NOMATCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         low_ff       <= udpd_pkg::EPHEM_LOW_RESET;
         high_ff      <= udpd_pkg::EPHEM_HIGH_RESET;
         cursor_ff    <= udpd_pkg::CURSOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      port_ff   <= port_in;
      addr_ff   <= addr_in;
      exact_ff  <= exact_in;
      wild_ff   <= wild_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      count_ff  <= count_in;
      chosen_ff <= chosen_in;
      eph_ok_ff <= eph_ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/udp_port_bind_demux_table.sv -----
// Channel   Ports                           Handshake
// request   start, busy, req_data           taken when start is high and busy is low
// result    rsp_valid, rsp_data             one-cycle strobe, cannot be held off
// control   csr_we, csr_index, csr_wdata    written on any edge with csr_we high
//
// Bind with a port, lookup and unbind: the item passes the compare and finish states
// and the result strobe is registered; the next item may be taken in the strobe cycle.
// Ephemeral bind and pick add a cursor init and a probe step per port probed (1 up to the
// range size) before finish; one cursor port is compared against every slot per cycle.
// Reset is synchronous; it empties the table and loads the range and cursor defaults.
`include "udp_port_bind_demux_table_defines.svh"

module udp_port_bind_demux_table #(
   parameter int SLOTS = udpd_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  udpd_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output udpd_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [udpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata
);

   udpd_pkg::cmd_type cmd;
   udpd_pkg::sts_type sts;
   logic              rsp_fail;
   logic              rsp_blank;

   udpd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   udpd_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_fail  = rsp_valid && (rsp_data.status != udpd_pkg::ST_OK);
   assign rsp_blank = (rsp_data.result_slot == 5'd0) && (rsp_data.result_port == 16'd0);

   `UDPD_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "result strobe while still busy")
   `UDPD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `UDPD_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "several datapath commands at once")
   `UDPD_ASSERT_NOW(a_fail_zero, rsp_fail, rsp_blank, "failed item carries slot or port")

endmodule

// ----- tb/sv/udp_port_bind_demux_table_test.sv -----
module udp_port_bind_demux_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT      = udpd_pkg::SLOTS_DEFAULT;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_LEN  = 660;
   localparam int CHUNK      = 110;
   localparam int MAX_SHOWN  = 10;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   udpd_pkg::req_type              req_data;
   logic                           rsp_valid;
   udpd_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [udpd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                    csr_wdata;

   udp_port_bind_demux_table DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow copy of the binding table and the range registers
   bit          bound [NSLOT];
   logic [15:0] bound_port [NSLOT];
   logic [31:0] bound_addr [NSLOT];
   logic [15:0] eph_cursor;
   logic [15:0] eph_low;
   logic [15:0] eph_high;

   udpd_pkg::rsp_type rsp_due [$];

   int idle_pct;
   int mismatches;
   int items_sent;
   int results_checked;
   int full_seen;
   int inuse_seen;
   int nomatch_seen;
   int ranges_used;
   int quiet_cycles;
   bit filling;

   function automatic void reset_model();
      int i;
      for (i = 0; i < NSLOT; i++) begin
         bound[i] = 1'b0;
         bound_port[i] = '0;
         bound_addr[i] = '0;
      end
      eph_low = udpd_pkg::EPHEM_LOW_RESET;
      eph_high = udpd_pkg::EPHEM_HIGH_RESET;
      eph_cursor = udpd_pkg::CURSOR_RESET;
   endfunction

   function automatic bit port_taken(logic [15:0] p);
      int i;
      for (i = 0; i < NSLOT; i++)
         if (bound[i] && bound_port[i] == p) return 1'b1;
      return 1'b0;
   endfunction

   // rotate the cursor through the effective range; 0 means every port is taken
   function automatic logic [15:0] take_ephemeral();
      int lo, hi, span, n;
      logic [15:0] p;
      lo = (eph_low == 16'd0) ? 1 : int'(eph_low);
      hi = (int'(eph_high) < lo) ? lo : int'(eph_high);
      span = hi - lo + 1;
      if (int'(eph_cursor) < lo || int'(eph_cursor) > hi) eph_cursor = 16'(lo);
      for (n = 0; n < span; n++) begin
         p = eph_cursor;
         eph_cursor = (int'(p) >= hi) ? 16'(lo) : p + 16'd1;
         if (!port_taken(p)) return p;
      end
      return 16'd0;
   endfunction

   function automatic udpd_pkg::rsp_type apply_table_op(udpd_pkg::req_type it);
      udpd_pkg::rsp_type r;
      logic dup;
      logic done;
      logic [15:0] p;
      int exact, wild, i;
      r.status = udpd_pkg::ST_NOMATCH;
      r.result_slot = '0;
      r.result_port = '0;
      case (it.mode)
         udpd_pkg::MODE_BIND: begin
            dup = 1'b0;
            p = it.port;
            if (p == 16'd0) begin
               p = take_ephemeral();
               dup = (p == 16'd0);
            end else begin
               for (i = 0; i < NSLOT; i++)
                  if (bound[i] && bound_port[i] == p && bound_addr[i] == it.addr) dup = 1'b1;
            end
            if (dup) begin
               r.status = udpd_pkg::ST_INUSE;
            end else begin
               r.status = udpd_pkg::ST_FULL;
               done = 1'b0;
               for (i = 0; i < NSLOT; i++) begin
                  if (!done && !bound[i]) begin
                     bound[i] = 1'b1;
                     bound_port[i] = p;
                     bound_addr[i] = it.addr;
                     r.status = udpd_pkg::ST_OK;
                     r.result_slot = 5'(i);
                     r.result_port = p;
                     done = 1'b1;
                  end
               end
            end
         end
         udpd_pkg::MODE_LOOKUP: begin
            exact = -1;
            wild = -1;
            for (i = 0; i < NSLOT; i++) begin
               if (bound[i] && bound_port[i] == it.port) begin
                  if (bound_addr[i] == it.addr && exact < 0) exact = i;
                  if (bound_addr[i] == 32'd0 && wild < 0) wild = i;
               end
            end
            if (exact < 0) exact = wild;
            if (exact >= 0) begin
               r.status = udpd_pkg::ST_OK;
               r.result_slot = 5'(exact);
               r.result_port = it.port;
            end
         end
         udpd_pkg::MODE_UNBIND: begin
            if (int'(it.slot) < NSLOT && bound[it.slot]) begin
               bound[it.slot] = 1'b0;
               r.status = udpd_pkg::ST_OK;
               r.result_slot = it.slot;
               r.result_port = bound_port[it.slot];
            end
         end
         default: begin
            p = take_ephemeral();
            if (p == 16'd0) begin
               r.status = udpd_pkg::ST_INUSE;
            end else begin
               r.status = udpd_pkg::ST_OK;
               r.result_port = p;
            end
         end
      endcase
      return r;
   endfunction

   function automatic udpd_pkg::req_type op_item(udpd_pkg::mode_type m, logic [15:0] p,
                                                 logic [31:0] a, logic [4:0] s);
      udpd_pkg::req_type it;
      it.mode = m;
      it.port = p;
      it.addr = a;
      it.slot = s;
      return it;
   endfunction

   function automatic int random_bound_slot();
      int cnt, k, i;
      cnt = 0;
      for (i = 0; i < NSLOT; i++)
         if (bound[i]) cnt++;
      if (cnt == 0) return -1;
      k = $urandom_range(0, cnt - 1);
      for (i = 0; i < NSLOT; i++) begin
         if (bound[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   // alternate fill and drain stretches so the table reaches full and empty
   function automatic udpd_pkg::req_type make_item();
      udpd_pkg::req_type it;
      int used, i, s, k;
      used = 0;
      for (i = 0; i < NSLOT; i++)
         if (bound[i]) used++;
      if (used == NSLOT) filling = 1'b0;
      else if (used == 0) filling = 1'b1;
      it.port = 16'($urandom_range(0, 65535));
      it.addr = $urandom;
      it.slot = 5'($urandom_range(0, 31));
      k = $urandom_range(0, 99);
      if (filling)
         it.mode = (k < 55) ? udpd_pkg::MODE_BIND :
                   (k < 72) ? udpd_pkg::MODE_LOOKUP :
                   (k < 85) ? udpd_pkg::MODE_UNBIND : udpd_pkg::MODE_PICK;
      else
         it.mode = (k < 20) ? udpd_pkg::MODE_BIND :
                   (k < 40) ? udpd_pkg::MODE_LOOKUP :
                   (k < 85) ? udpd_pkg::MODE_UNBIND : udpd_pkg::MODE_PICK;
      s = random_bound_slot();
      case (it.mode)
         udpd_pkg::MODE_BIND: begin
            k = $urandom_range(0, 99);
            if (k < 40) it.port = '0;
            else if (k < 65 && s >= 0) it.port = bound_port[s];
            else if (k < 80) it.port = 16'($urandom_range(1, 8));
            k = $urandom_range(0, 99);
            if (k < 30) it.addr = '0;
            else if (k < 60 && s >= 0) it.addr = bound_addr[s];
         end
         udpd_pkg::MODE_LOOKUP: begin
            if (s >= 0 && $urandom_range(0, 99) < 75) begin
               it.port = bound_port[s];
               k = $urandom_range(0, 99);
               if (k < 45) it.addr = bound_addr[s];
               else if (k < 60) it.addr = '0;
            end
         end
         udpd_pkg::MODE_UNBIND: begin
            if (s >= 0 && $urandom_range(0, 99) < 80) it.slot = 5'(s);
         end
         default: ;
      endcase
      return it;
   endfunction

   // start stays high from one item to the next unless an idle cycle is drawn
   task automatic send_item(input udpd_pkg::req_type it);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      rsp_due.push_back(apply_table_op(it));
      items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_range(input logic [15:0] lo, input logic [15:0] hi);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= udpd_pkg::CSR_EPHEM_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= udpd_pkg::CSR_EPHEM_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      eph_low = lo;
      eph_high = hi;
      ranges_used++;
   endtask

   task automatic pick_range();
      logic [15:0] lo, hi;
      case ($urandom_range(0, 6))
         0: begin
            lo = udpd_pkg::EPHEM_LOW_RESET;
            hi = udpd_pkg::EPHEM_HIGH_RESET;
         end
         1: begin
            lo = 16'd1;
            hi = 16'hFFFF;
         end
         2: begin
            lo = 16'd0;
            hi = 16'($urandom_range(0, 40));
         end
         3: begin
            lo = 16'($urandom_range(2, 65535));
            hi = 16'($urandom_range(0, lo - 1));
         end
         4: begin
            lo = 16'($urandom_range(65500, 65535));
            hi = 16'hFFFF;
         end
         5: begin
            lo = 16'($urandom_range(1, 65500));
            hi = lo + 16'($urandom_range(0, 35));
         end
         default: begin
            lo = 16'($urandom_range(0, 65535));
            hi = lo;
         end
      endcase
      write_range(lo, hi);
   endtask

   task automatic report_bad(input bit stray, input udpd_pkg::rsp_type want,
                             input udpd_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
         if (stray)
            $display("unexpected result: status %0d slot %0d port %0d",
                     got.status, got.result_slot, got.result_port);
         else
            $display("mismatch: expected status %0d slot %0d port %0d, got status %0d slot %0d port %0d",
                     want.status, want.result_slot, want.result_port,
                     got.status, got.result_slot, got.result_port);
      end
   endtask

   always @(posedge clock) begin
      udpd_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            report_bad(1'b1, rsp_data, rsp_data);
         end else begin
            want = rsp_due.pop_front();
            results_checked++;
            if (rsp_data.status !== want.status || rsp_data.result_slot !== want.result_slot
                || rsp_data.result_port !== want.result_port)
               report_bad(1'b0, want, rsp_data);
            else if (want.status == udpd_pkg::ST_FULL) full_seen++;
            else if (want.status == udpd_pkg::ST_INUSE) inuse_seen++;
            else if (want.status == udpd_pkg::ST_NOMATCH) nomatch_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("** udp_port_bind_demux_table: FAILED **");
      $finish;
   end

   task automatic test_bind_lookup_unbind();
      idle_pct = 18;
      send_item(op_item(udpd_pkg::MODE_BIND, 16'd0, 32'h0A00_0001, 5'd0));
      send_item(op_item(udpd_pkg::MODE_PICK, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_BIND, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
      // exact duplicate, then the wildcard on the same port
      send_item(op_item(udpd_pkg::MODE_BIND, 16'hFFFF, 32'hFFFF_FFFF, 5'd0));
      send_item(op_item(udpd_pkg::MODE_BIND, 16'hFFFF, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 5'd0));
      send_item(op_item(udpd_pkg::MODE_LOOKUP, 16'hFFFF, 32'h1234_5678, 5'd0));
      send_item(op_item(udpd_pkg::MODE_LOOKUP, 16'd1, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_LOOKUP, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_UNBIND, 16'd0, 32'd0, 5'd31));
      send_item(op_item(udpd_pkg::MODE_UNBIND, 16'hFFFF, 32'hFFFF_FFFF, 5'd1));
      send_item(op_item(udpd_pkg::MODE_UNBIND, 16'd0, 32'd0, 5'd1));
      send_item(op_item(udpd_pkg::MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 5'd0));
   endtask

   task automatic test_ephemeral_range();
      // low of 0 acts as 1 and the cursor starts outside the range
      write_range(16'd0, 16'd2);
      send_item(op_item(udpd_pkg::MODE_BIND, 16'd0, 32'hC0A8_0101, 5'd0));
      send_item(op_item(udpd_pkg::MODE_BIND, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_PICK, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_BIND, 16'd0, 32'h7F00_0001, 5'd0));
      // high below low leaves the single port low
      write_range(16'hFFFF, 16'd100);
      send_item(op_item(udpd_pkg::MODE_PICK, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_UNBIND, 16'd0, 32'd0, 5'd2));
      send_item(op_item(udpd_pkg::MODE_PICK, 16'd0, 32'd0, 5'd0));
      send_item(op_item(udpd_pkg::MODE_BIND, 16'd0, 32'd0, 5'd0));
      write_range(udpd_pkg::EPHEM_LOW_RESET, udpd_pkg::EPHEM_HIGH_RESET);
      send_item(op_item(udpd_pkg::MODE_PICK, 16'd0, 32'd0, 5'd0));
   endtask

   task automatic test_random_traffic(input int pct, input int count);
      int n;
      idle_pct = pct;
      for (n = 0; n < count; n++) begin
         if (n % CHUNK == 0) pick_range();
         send_item(make_item());
      end
   endtask

   initial begin
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset <= 1'b1;
      filling = 1'b1;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_bind_lookup_unbind();
      test_ephemeral_range();
      test_random_traffic(18, PHASE_LEN);
      test_random_traffic(84, PHASE_LEN);
      test_random_traffic(0, PHASE_LEN);

      wait_idle();
      repeat (8) @(posedge clock);
      $display("covered %0d items over %0d range settings, %0d results checked",
               items_sent, ranges_used, results_checked);
      $display("  table full %0d, address in use %0d, no match %0d, mismatches %0d",
               full_seen, inuse_seen, nomatch_seen, mismatches);
      if (mismatches == 0 && rsp_due.size() == 0)
         $display("** udp_port_bind_demux_table: PASSED **");
      else
         $display("** udp_port_bind_demux_table: FAILED **");
      $finish;
   end

endmodule
